/* sv/r2fft_pkg.sv */
// Shared types, codes and helper functions for the radix-2 FFT core.
`timescale 1ns / 1ps

package r2fft_pkg;

    // Command codes carried in the input beat
    typedef enum logic [1:0] {
        CMD_STORE  = 2'd0,
        CMD_RUN    = 2'd1,
        CMD_READ   = 2'd2,
        CMD_READ_B = 2'd3
    } cmd_t;

    // Status codes carried in the result beat
    typedef enum logic [1:0] {
        STAT_STORED = 2'd0,
        STAT_DONE   = 2'd1,
        STAT_BIN    = 2'd2
    } status_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ_BIN,
        ST_RA,
        ST_RB,
        ST_LB,
        ST_M0,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_M4,
        ST_WA,
        ST_WB,
        ST_DONE
    } state_t;

    // What the shared unit does with one pair
    typedef enum logic [1:0] {
        BF_UNITY,
        BF_MINUS_J,
        BF_TABLE,
        BF_SWAP
    } bf_mode_t;

    // Multiplier step of the twiddle product
    typedef enum logic [2:0] {
        MS_NONE,
        MS_M0,
        MS_M1,
        MS_M2,
        MS_M3,
        MS_M4
    } mul_step_t;

    typedef struct packed {
        logic      load_a;
        logic      load_b;
        bf_mode_t  mode;
        mul_step_t step;
    } bf_ctrl_t;

    localparam logic [63:0] PI_Q60  = 64'h3243F6A8885A308D;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
    localparam int          TW_MAX  = 24;

    // Saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // Q30 value to twiddle format, negatives clamped to zero, large values to the largest positive code
    function automatic longint to_tw(input longint q30, input int tw);
        int     sh;
        longint r;
        longint lim;
        longint q;
        sh  = 31 - tw;
        lim = (longint'(1) <<< (tw - 1)) - 1;
        q   = (q30 < 0) ? longint'(0) : q30;
        r   = (q + (longint'(1) <<< (sh - 1))) >>> sh;
        return (r > lim) ? lim : r;
    endfunction

    // Twiddle entry k of a 2^lgm point table: {-sin, cos}, each TW_MAX bits
    function automatic logic [2*TW_MAX-1:0] tw_entry(input int k, input int lgm,
                                                     input int tw);
        logic [63:0] mm;
        logic [63:0] qq;
        logic [63:0] kk;
        logic [63:0] m;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] tc;
        logic [63:0] ts;
        longint      cs;
        longint      ss;
        longint      a;
        longint      b;
        longint      c;
        longint      s;
        logic [63:0] ns;
        logic [63:0] cc;
        mm = 64'd1 << lgm;
        qq = mm >> 2;
        kk = 64'(k);
        if ((kk << 3) <= mm) begin
            m = kk;
        end else if ((kk << 2) <= mm) begin
            m = qq - kk;
        end else if ((kk << 3) <= 3 * mm) begin
            m = kk - qq;
        end else begin
            m = (qq << 1) - kk;
        end
        x  = ((PI_Q60 >> (lgm - 1)) * m) >> 30;
        x2 = (x * x) >> 30;
        tc = ONE_Q30;
        ts = x;
        cs = longint'(ONE_Q30);
        ss = longint'(x);
        // Taylor terms, alternating sign
        tc = ((tc * x2) >> 30) / 2;   ts = ((ts * x2) >> 30) / 6;
        cs = cs - longint'(tc);       ss = ss - longint'(ts);
        tc = ((tc * x2) >> 30) / 12;  ts = ((ts * x2) >> 30) / 20;
        cs = cs + longint'(tc);       ss = ss + longint'(ts);
        tc = ((tc * x2) >> 30) / 30;  ts = ((ts * x2) >> 30) / 42;
        cs = cs - longint'(tc);       ss = ss - longint'(ts);
        tc = ((tc * x2) >> 30) / 56;  ts = ((ts * x2) >> 30) / 72;
        cs = cs + longint'(tc);       ss = ss + longint'(ts);
        tc = ((tc * x2) >> 30) / 90;  ts = ((ts * x2) >> 30) / 110;
        cs = cs - longint'(tc);       ss = ss - longint'(ts);
        tc = ((tc * x2) >> 30) / 132; ts = ((ts * x2) >> 30) / 156;
        cs = cs + longint'(tc);       ss = ss + longint'(ts);
        tc = ((tc * x2) >> 30) / 182; ts = ((ts * x2) >> 30) / 210;
        cs = cs - longint'(tc);       ss = ss - longint'(ts);
        tc = ((tc * x2) >> 30) / 240; ts = ((ts * x2) >> 30) / 272;
        cs = cs + longint'(tc);       ss = ss + longint'(ts);
        a = to_tw(cs, tw);
        b = to_tw(ss, tw);
        // Fold the octant back onto the half circle
        if ((kk << 3) <= mm) begin
            c = a;  s = b;
        end else if ((kk << 2) <= mm) begin
            c = b;  s = a;
        end else if ((kk << 3) <= 3 * mm) begin
            c = -b; s = a;
        end else begin
            c = -a; s = b;
        end
        ns = 64'(-s);
        cc = 64'(c);
        return {ns[TW_MAX-1:0], cc[TW_MAX-1:0]};
    endfunction

endpackage

/* sv/r2fft_mem.sv */
// Single-port sample store, complex word {imag, real}, registered read.
`timescale 1ns / 1ps

module r2fft_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          aclk,
    input  logic          en,
    input  logic          we,
    input  logic [AW-1:0] addr,
    input  logic [63:0]   wdata,
    output logic [63:0]   rdata
);

    logic [63:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (en && we) begin
            mem[addr] <= wdata;
        end
    end

    // Read port, hold data while idle
    always_ff @(posedge aclk) begin
        if (en && !we) begin
            rdata <= mem[addr];
        end
    end

endmodule

/* sv/r2fft_twiddle.sv */
// Constant twiddle table with registered read.
`timescale 1ns / 1ps

module r2fft_twiddle #(
    parameter int MAX_POINTS   = 1024,
    parameter int TWIDDLE_BITS = 18
) (
    input  logic                                 aclk,
    input  logic [$clog2(MAX_POINTS)-2:0]        addr,
    output logic signed [TWIDDLE_BITS-1:0]       w_re,
    output logic signed [TWIDDLE_BITS-1:0]       w_im
);
    import r2fft_pkg::*;

    localparam int HALF  = MAX_POINTS / 2;
    localparam int LOG_M = $clog2(MAX_POINTS);

    logic [2*TWIDDLE_BITS-1:0] rom [HALF];

    // Build the table at elaboration
    for (genvar g = 0; g < HALF; g++) begin : g_rom
        localparam logic [2*TW_MAX-1:0] ENTRY = tw_entry(g, LOG_M, TWIDDLE_BITS);
        assign rom[g] = {ENTRY[TW_MAX +: TWIDDLE_BITS], ENTRY[TWIDDLE_BITS-1:0]};
    end

    // Registered lookup
    always_ff @(posedge aclk) begin
        w_re <= rom[addr][TWIDDLE_BITS-1:0];
        w_im <= rom[addr][2*TWIDDLE_BITS-1:TWIDDLE_BITS];
    end

endmodule

/* sv/r2fft_bfly.sv */
// Shared butterfly unit: sum, difference and one time-shared twiddle multiplier.
`timescale 1ns / 1ps

module r2fft_bfly #(
    parameter int TWIDDLE_BITS = 18
) (
    input  logic                           aclk,
    input  r2fft_pkg::bf_ctrl_t            ctrl,
    input  logic [63:0]                    rdata,
    input  logic signed [TWIDDLE_BITS-1:0] w_re,
    input  logic signed [TWIDDLE_BITS-1:0] w_im,
    output logic [63:0]                    out_a,
    output logic [63:0]                    out_b
);
    import r2fft_pkg::*;

    localparam int PW = 33 + TWIDDLE_BITS;
    localparam logic signed [PW:0] RND = (PW+1)'(1) <<< (TWIDDLE_BITS - 2);

    logic [63:0]             a_reg;
    logic [63:0]             sum_reg;
    logic signed [32:0]      dre_reg;
    logic signed [32:0]      dim_reg;
    logic signed [31:0]      ore_reg;
    logic signed [31:0]      oim_reg;
    logic signed [PW-1:0]    prod_reg;
    logic signed [PW-1:0]    acc_reg;

    logic signed [31:0]      ar, ai, br, bi;
    logic signed [32:0]      sr, si, dr, di;
    logic signed [31:0]      dr_sat, di_sat;
    logic signed [32:0]      op_d;
    logic signed [TWIDDLE_BITS-1:0] op_w;
    logic signed [PW:0]      rsum_re;
    logic signed [PW:0]      rsum_im;
    logic signed [PW:0]      sh_re;
    logic signed [PW:0]      sh_im;

    // Pair arithmetic on the held first word and the arriving second word
    always_comb begin
        ar     = a_reg[31:0];
        ai     = a_reg[63:32];
        br     = rdata[31:0];
        bi     = rdata[63:32];
        sr     = 33'(ar) + 33'(br);
        si     = 33'(ai) + 33'(bi);
        dr     = 33'(ar) - 33'(br);
        di     = 33'(ai) - 33'(bi);
        dr_sat = sat32(64'(dr));
        di_sat = sat32(64'(di));
    end

    // Multiplier operand selection per step
    always_comb begin
        op_d = (ctrl.step == MS_M0 || ctrl.step == MS_M2) ? dre_reg : dim_reg;
        op_w = (ctrl.step == MS_M0 || ctrl.step == MS_M3) ? w_re : w_im;
    end

    // Round half up at the twiddle point
    always_comb begin
        rsum_re = (PW+1)'(acc_reg) - (PW+1)'(prod_reg) + RND;
        rsum_im = (PW+1)'(acc_reg) + (PW+1)'(prod_reg) + RND;
        sh_re   = rsum_re >>> (TWIDDLE_BITS - 1);
        sh_im   = rsum_im >>> (TWIDDLE_BITS - 1);
    end

    // Capture the first word
    always_ff @(posedge aclk) begin
        if (ctrl.load_a) begin
            a_reg <= rdata;
        end
    end

    // Form sum, difference and the plain second result
    always_ff @(posedge aclk) begin
        if (ctrl.load_b) begin
            sum_reg <= (ctrl.mode == BF_SWAP) ? rdata : {sat32(64'(si)), sat32(64'(sr))};
            dre_reg <= dr;
            dim_reg <= di;
            unique case (ctrl.mode)
                BF_UNITY: begin
                    ore_reg <= dr_sat;
                    oim_reg <= di_sat;
                end
                BF_MINUS_J: begin
                    ore_reg <= di_sat;
                    oim_reg <= sat32(-64'(dr_sat));
                end
                BF_SWAP: begin
                    ore_reg <= ar;
                    oim_reg <= ai;
                end
                default: begin
                    ore_reg <= dr_sat;
                    oim_reg <= di_sat;
                end
            endcase
        end else begin
            unique case (ctrl.step)
                MS_M2:   ore_reg <= sat32(64'(sh_re));
                MS_M4:   oim_reg <= sat32(64'(sh_im));
                default: ;
            endcase
        end
    end

    // Multiply, register, then accumulate
    always_ff @(posedge aclk) begin
        prod_reg <= PW'(op_d) * PW'(op_w);
        if (ctrl.step == MS_M1 || ctrl.step == MS_M3) begin
            acc_reg <= prod_reg;
        end
    end

    assign out_a = sum_reg;
    assign out_b = {oim_reg, ore_reg};

endmodule

/* sv/radix2_dif_fft_in_place_core.sv */
// Top level: command decode, transform sequencer and result register.
//
//  Channel   Direction  Beat contents (low bit first)
//  s_*       in         cmd[1:0], position[11:2], sample_re[27:12], sample_im[43:28]
//  m_*       out        bin_re[31:0], bin_im[63:32], status[65:64]
//  cfg_*     in         log2_points[3:0], written when cfg_wr_en is high
//
// A store is written from the idle state; a read goes through ST_READ_BIN. A run
// steps one butterfly at a time through the single-port store (read both words,
// load, the twiddle product steps M0 to M4 where needed, write both words), N/2
// pairs per stage over log2 N stages, then a bit-reversal reorder pass and a report.
// Reset is synchronous, active low; the store contents are not cleared.
// The input stalls while a command is at work or a result waits unclaimed.
`timescale 1ns / 1ps

module radix2_dif_fft_in_place_core #(
    parameter int MAX_POINTS   = 1024,
    parameter int TWIDDLE_BITS = 18
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // cmd, position, sample_re, sample_im
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // bin_re, bin_im, status
    input  logic        cfg_wr_en,
    input  logic [3:0]  cfg_wr_data // log2_points
);
    import r2fft_pkg::*;

    localparam int AW    = $clog2(MAX_POINTS);
    localparam int MAXLOG = AW;
    localparam int LGW   = $clog2(MAXLOG + 1);

    state_t         state_reg, state_next;
    logic [3:0]     lg_cfg_reg;
    logic [LGW-1:0] stage_reg;
    logic [AW-1:0]  k_reg;
    logic           rev_reg;
    logic           m_valid_reg;
    logic [65:0]    m_data_reg;

    cmd_t           s_cmd;
    logic [9:0]     s_pos;
    logic [15:0]    s_re;
    logic [15:0]    s_im;
    logic           accept;
    logic           is_run;
    logic           is_read;

    logic [LGW-1:0] lg;
    logic [AW-1:0]  n_mask;
    logic [AW-1:0]  pos_addr;
    logic [LGW-1:0] half_log;
    logic [LGW-1:0] tw_sh;
    logic [AW-1:0]  j_mask;
    logic [AW-1:0]  jj;
    logic [AW-1:0]  bf_a;
    logic [AW-1:0]  bf_b;
    logic [AW-1:0]  tw_full;
    logic [AW-1:0]  rev_full;
    logic [AW-1:0]  rev_k;
    logic [AW-1:0]  ia;
    logic [AW-1:0]  ib;
    logic           skip;
    logic           last_k;
    logic           all_done;
    bf_mode_t       mode;

    logic           mem_en;
    logic           mem_we;
    logic [AW-1:0]  mem_addr;
    logic [63:0]    mem_wdata;
    logic [63:0]    mem_rdata;
    bf_ctrl_t       bf_ctrl;
    logic [63:0]    out_a;
    logic [63:0]    out_b;
    logic signed [TWIDDLE_BITS-1:0] w_re;
    logic signed [TWIDDLE_BITS-1:0] w_im;
    logic           adv;
    logic           out_load;
    status_t        out_status;
    logic [63:0]    out_bin;

    // Unpack the input beat
    assign s_cmd   = cmd_t'(s_tdata[1:0]);
    assign s_pos   = s_tdata[11:2];
    assign s_re    = s_tdata[27:12];
    assign s_im    = s_tdata[43:28];
    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept  = s_tvalid && s_tready;
    assign is_run  = (s_cmd == CMD_RUN);
    assign is_read = (s_cmd == CMD_READ) || (s_cmd == CMD_READ_B);

    // Clamp the length in use
    always_comb begin
        if (lg_cfg_reg < 4'd2) begin
            lg = LGW'(2);
        end else if (int'(lg_cfg_reg) > MAXLOG) begin
            lg = LGW'(MAXLOG);
        end else begin
            lg = LGW'(lg_cfg_reg);
        end
        n_mask   = {AW{1'b1}} >> (LGW'(AW) - lg);
        pos_addr = AW'(s_pos) & n_mask;
    end

    // Pair addressing, twiddle index and mode
    always_comb begin
        half_log = lg - stage_reg;
        tw_sh    = LGW'(MAXLOG - 1) - half_log;
        j_mask   = ~({AW{1'b1}} << half_log);
        jj       = k_reg & j_mask;
        bf_a     = ((k_reg & ~j_mask) << 1) | jj;
        bf_b     = bf_a | (AW'(1) << half_log);
        tw_full  = jj << tw_sh;
        for (int b = 0; b < AW; b++) begin
            rev_full[b] = k_reg[AW-1-b];
        end
        rev_k    = rev_full >> (LGW'(AW) - lg);
        ia       = rev_reg ? k_reg : bf_a;
        ib       = rev_reg ? rev_k : bf_b;
        skip     = rev_reg && !(k_reg < rev_k);
        last_k   = rev_reg ? (k_reg == n_mask) : (k_reg == (n_mask >> 1));
        all_done = rev_reg && last_k;
        if (rev_reg) begin
            mode = BF_SWAP;
        end else if (stage_reg == lg) begin
            mode = BF_UNITY;
        end else if (stage_reg == lg - LGW'(1)) begin
            mode = (jj == '0) ? BF_UNITY : BF_MINUS_J;
        end else begin
            mode = (jj == '0) ? BF_UNITY : BF_TABLE;
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_run) begin
                    state_next = ST_RA;
                end else if (accept && is_read) begin
                    state_next = ST_READ_BIN;
                end
            end
            ST_READ_BIN: state_next = ST_IDLE;
            ST_RA: begin
                if (skip) begin
                    state_next = all_done ? ST_DONE : ST_RA;
                end else begin
                    state_next = ST_RB;
                end
            end
            ST_RB: state_next = ST_LB;
            ST_LB: state_next = (mode == BF_TABLE) ? ST_M0 : ST_WA;
            ST_M0: state_next = ST_M1;
            ST_M1: state_next = ST_M2;
            ST_M2: state_next = ST_M3;
            ST_M3: state_next = ST_M4;
            ST_M4: state_next = ST_WA;
            ST_WA: state_next = ST_WB;
            ST_WB: state_next = all_done ? ST_DONE : ST_RA;
            ST_DONE: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb begin
        mem_en     = 1'b0;
        mem_we     = 1'b0;
        mem_addr   = ia;
        mem_wdata  = out_a;
        bf_ctrl    = '{load_a: 1'b0, load_b: 1'b0, mode: mode, step: MS_NONE};
        adv        = 1'b0;
        out_load   = 1'b0;
        out_status = STAT_STORED;
        out_bin    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                mem_en    = accept && !is_run;
                mem_we    = !is_read;
                mem_addr  = pos_addr;
                mem_wdata = {{16{s_im[15]}}, s_im, {16{s_re[15]}}, s_re};
                out_load  = accept && !is_run && !is_read;
            end
            ST_READ_BIN: begin
                out_load   = 1'b1;
                out_status = STAT_BIN;
                out_bin    = mem_rdata;
            end
            ST_RA: begin
                mem_en = !skip;
                adv    = skip;
            end
            ST_RB: begin
                mem_en         = 1'b1;
                mem_addr       = ib;
                bf_ctrl.load_a = 1'b1;
            end
            ST_LB: bf_ctrl.load_b = 1'b1;
            ST_M0: bf_ctrl.step = MS_M0;
            ST_M1: bf_ctrl.step = MS_M1;
            ST_M2: bf_ctrl.step = MS_M2;
            ST_M3: bf_ctrl.step = MS_M3;
            ST_M4: bf_ctrl.step = MS_M4;
            ST_WA: begin
                mem_en = 1'b1;
                mem_we = 1'b1;
            end
            ST_WB: begin
                mem_en    = 1'b1;
                mem_we    = 1'b1;
                mem_addr  = ib;
                mem_wdata = out_b;
                adv       = 1'b1;
            end
            ST_DONE: begin
                out_load   = 1'b1;
                out_status = STAT_DONE;
            end
            default: ;
        endcase
    end

    // State, configuration and pass counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            lg_cfg_reg <= 4'd10;
            stage_reg  <= LGW'(1);
            k_reg      <= '0;
            rev_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                lg_cfg_reg <= cfg_wr_data;
            end
            if (accept && is_run) begin
                stage_reg <= LGW'(1);
                k_reg     <= '0;
                rev_reg   <= 1'b0;
            end else if (adv) begin
                if (!last_k) begin
                    k_reg <= k_reg + AW'(1);
                end else if (!rev_reg) begin
                    k_reg <= '0;
                    if (stage_reg == lg) begin
                        rev_reg <= 1'b1;
                    end else begin
                        stage_reg <= stage_reg + LGW'(1);
                    end
                end
            end
        end
    end

    // Result register: load on completion, drop when taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg <= {out_status, out_bin[63:32], out_bin[31:0]};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_data_reg};

    r2fft_mem #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .en    (mem_en),
        .we    (mem_we),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

    r2fft_twiddle #(
        .MAX_POINTS   (MAX_POINTS),
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_twiddle (
        .aclk (aclk),
        .addr (tw_full[AW-2:0]),
        .w_re (w_re),
        .w_im (w_im)
    );

    r2fft_bfly #(
        .TWIDDLE_BITS (TWIDDLE_BITS)
    ) u_bfly (
        .aclk  (aclk),
        .ctrl  (bf_ctrl),
        .rdata (mem_rdata),
        .w_re  (w_re),
        .w_im  (w_im),
        .out_a (out_a),
        .out_b (out_b)
    );

    // No result may be pending while a command is at work
    a_no_result_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !m_valid_reg)
        else $error("result pending while busy");

    // Butterfly stage stays within the length in use
    a_stage_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB && !rev_reg) |-> (stage_reg >= LGW'(1) && stage_reg <= lg))
        else $error("stage out of range");

    // Second word of a pair lies above the first
    a_pair_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WB) |-> (ib > ia))
        else $error("pair addresses out of order");

    // A finished run is reported in the next cycle
    a_done_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) |=> (m_valid_reg && m_data_reg[65:64] == STAT_DONE))
        else $error("run completion not reported");

endmodule
